// File: rtl/rtim_pkg.sv
// Shared types, codes and constants of the region type interval map.
`default_nettype none
package rtim_pkg;

    localparam int ADDR_BITS    = 16;
    localparam int TYPE_BITS    = 3;
    localparam int STATUS_BITS  = 2;
    localparam int COUNT_BITS   = 7;
    localparam int DEPTH_DEFAULT = 64;

    localparam logic [ADDR_BITS:0] ADDR_LIMIT = {1'b1, {ADDR_BITS{1'b0}}};

    localparam logic OP_ASSIGN = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                 opcode;
        logic [ADDR_BITS-1:0] range_start;
        logic [ADDR_BITS:0]   range_end;
        logic [TYPE_BITS-1:0] region_type;
        logic [ADDR_BITS-1:0] query_address;
    } in_t;

    typedef struct packed {
        logic [TYPE_BITS-1:0]   found_type;
        logic [STATUS_BITS-1:0] status;
        logic [COUNT_BITS-1:0]  boundary_count;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_LOW,
        S_INS_S,
        S_MID,
        S_INS_E,
        S_HIGH,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// File: rtl/rtim_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rtim_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/region_type_interval_map_top.sv
// Top level of the region type interval map: boundary table in two RAM banks.
// Lookup: one result after a scan of the live bank up to the query address.
// Assign: the scan reads one entry a cycle from
//   the live bank and writes the rebuilt table into the other bank, with two
//   insert steps between the scan phases. Empty ranges skip the scan and answer EMPTY.
// One word in flight at a time; the result register frees the input side.
// Reset: table holds one region of type 0 from address 0; no clearing pass.
`default_nettype none
module region_type_interval_map_top
    import rtim_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = IW + 1;
    localparam int EW = ADDR_BITS + 1 + TYPE_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    state_t                 state_reg, state_next;
    logic                   bank_reg, bank_next;
    logic                   init_reg, init_next;
    logic                   op_reg, op_next;
    logic [CW-1:0]          used_reg, used_next;
    logic [CW-1:0]          cur_reg, cur_next;
    logic [CW-1:0]          n_reg, n_next;
    logic [ADDR_BITS:0]     s_reg, s_next;
    logic [ADDR_BITS:0]     e_reg, e_next;
    logic [TYPE_BITS-1:0]   t_reg, t_next;
    logic [TYPE_BITS-1:0]   last_reg, last_next;
    logic [TYPE_BITS-1:0]   run_reg, run_next;
    logic [STATUS_BITS-1:0] st_reg, st_next;
    logic                   out_valid_reg, out_valid_next;
    out_t                   out_data_reg, out_data_next;

    logic                   consume;
    logic                   em_req;
    logic [ADDR_BITS:0]     em_addr;
    logic [TYPE_BITS-1:0]   em_type;
    logic                   we;
    logic [IW-1:0]          raddr;
    logic [EW-1:0]          rd0, rd1, rd_sel;
    logic                   at_end;
    logic [ADDR_BITS:0]     ent_addr;
    logic [TYPE_BITS-1:0]   ent_type;
    logic [ADDR_BITS:0]     e_clamp;
    logic [CW-1:0]          cur_inc;

    rtim_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_bank0 (
        .clk   (clk),
        .we    (we && bank_reg),
        .waddr (n_reg[IW-1:0]),
        .wdata ({em_addr, em_type}),
        .raddr (raddr),
        .rdata (rd0)
    );

    rtim_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_bank1 (
        .clk   (clk),
        .we    (we && !bank_reg),
        .waddr (n_reg[IW-1:0]),
        .wdata ({em_addr, em_type}),
        .raddr (raddr),
        .rdata (rd1)
    );

    assign rd_sel   = bank_reg ? rd1 : rd0;
    assign at_end   = (cur_reg == used_reg);
    assign ent_addr = (cur_reg == '0) ? '0 : rd_sel[EW-1:TYPE_BITS];
    assign ent_type = (cur_reg == '0 && !init_reg) ? '0 : rd_sel[TYPE_BITS-1:0];
    assign e_clamp  = (in_data.range_end > ADDR_LIMIT) ? ADDR_LIMIT : in_data.range_end;
    assign cur_inc  = cur_reg + CW'(1);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bank_reg      <= 1'b0;
            init_reg      <= 1'b0;
            used_reg      <= CW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            init_reg      <= init_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        cur_reg      <= cur_next;
        n_reg        <= n_next;
        s_reg        <= s_next;
        e_reg        <= e_next;
        t_reg        <= t_next;
        last_reg     <= last_next;
        run_reg      <= run_next;
        st_reg       <= st_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        bank_next      = bank_reg;
        init_next      = init_reg;
        op_next        = op_reg;
        used_next      = used_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        t_next         = t_reg;
        last_next      = last_reg;
        run_next       = run_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        consume        = 1'b0;
        em_req         = 1'b0;
        em_addr        = ent_addr;
        em_type        = ent_type;
        we             = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = in_data.opcode;
                    cur_next  = '0;
                    n_next    = '0;
                    last_next = '0;
                    run_next  = '0;
                    st_next   = ST_DONE;
                    t_next    = in_data.region_type;
                    s_next    = {1'b0, in_data.range_start};
                    if (in_data.opcode == OP_LOOKUP)
                    begin
                        e_next     = {1'b0, in_data.query_address};
                        state_next = S_LOOK;
                    end
                    else
                    begin
                        e_next = e_clamp;
                        if ({1'b0, in_data.range_start} >= e_clamp)
                        begin
                            st_next    = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_LOW;
                        end
                    end
                end
            end
            S_LOOK, S_MID:
            begin
                if (at_end || ent_addr > e_reg)
                begin
                    state_next = (state_reg == S_LOOK) ? S_DONE : S_INS_E;
                end
                else
                begin
                    run_next = ent_type;
                    consume  = 1'b1;
                end
            end
            S_LOW:
            begin
                if (at_end || ent_addr >= s_reg)
                begin
                    state_next = S_INS_S;
                end
                else
                begin
                    run_next = ent_type;
                    em_req   = 1'b1;
                    consume  = 1'b1;
                end
            end
            S_INS_S:
            begin
                em_addr    = s_reg;
                em_type    = t_reg;
                em_req     = (n_reg == '0) || (last_reg != t_reg);
                last_next  = t_reg;
                state_next = S_MID;
            end
            S_INS_E:
            begin
                em_addr    = e_reg;
                em_type    = run_reg;
                em_req     = (e_reg != ADDR_LIMIT) && (run_reg != last_reg);
                state_next = S_HIGH;
            end
            S_HIGH:
            begin
                if (at_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    em_req  = 1'b1;
                    consume = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.found_type = (op_reg == OP_LOOKUP) ? run_reg : '0;
                    out_data_next.status     = (op_reg == OP_LOOKUP) ? ST_DONE : st_reg;
                    out_data_next.boundary_count = COUNT_BITS'(used_reg);
                    if (op_reg == OP_ASSIGN && st_reg == ST_DONE)
                    begin
                        bank_next = !bank_reg;
                        init_next = 1'b1;
                        used_next = n_reg;
                        out_data_next.boundary_count = COUNT_BITS'(n_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (em_req)
        begin
            if (n_reg == DEPTH_C)
            begin
                st_next    = ST_FULL;
                state_next = S_DONE;
            end
            else
            begin
                we        = 1'b1;
                n_next    = n_reg + CW'(1);
                last_next = em_type;
            end
        end

        if (consume)
        begin
            cur_next = cur_inc;
        end
    end

    assign raddr = (state_reg == S_IDLE) ? '0 : (consume ? cur_inc[IW-1:0] : cur_reg[IW-1:0]);

    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != '0 && used_reg <= DEPTH_C)
        else $error("boundary count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        we |-> n_reg < DEPTH_C)
        else $error("table write beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (bank_reg != $past(bank_reg)) |-> ($past(st_reg) == ST_DONE && $past(op_reg) == OP_ASSIGN))
        else $error("bank switch without a completed assign");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |-> !we)
        else $error("table write during lookup");

endmodule
`default_nettype wire
